### rtl/amqp_frame_deframer_macros.svh
// Assertion macros shared by the deframer RTL.
// Needs signals named clk and arst_n in the module that uses them.
`ifndef AMQP_FRAME_DEFRAMER_MACROS_SVH
`define AMQP_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AMQPD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("amqpd assertion failed");

// Next-cycle implication, checked outside reset.
`define AMQPD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("amqpd assertion failed");

`endif

### rtl/amqpd_pkg.sv
// Shared types and constants of the AMQP frame deframer.
// No dependencies; imported by every deframer module.
`timescale 1ns / 1ps

package amqpd_pkg;

	localparam int MIN_FRAME     = 8;
	localparam int MIN_DOFF      = 2;
	localparam int EXT_HDR_BYTES = 6;
	localparam int MAX_FRAME_RST = 512;
	localparam int CFG_IDX_W     = 3;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_EXT  = 2'd1;
	localparam logic [1:0] KIND_BODY = 2'd2;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_SIZE_LOW  = 3'd1;
	localparam logic [2:0] ERR_SIZE_HIGH = 3'd2;
	localparam logic [2:0] ERR_DOFF_LOW  = 3'd3;
	localparam logic [2:0] ERR_DOFF_HIGH = 3'd4;
	localparam logic [2:0] ERR_STUCK     = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_0    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_1    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_2    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_3    = 3'd4;

	typedef struct packed {
		logic [31:0]  frame_limit;
		logic [255:0] type_mask;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  out_byte;
		logic [7:0]  type_id;
		logic [31:0] body_size;
		logic        header_done;
		logic        body_last;
		logic [2:0]  error_code;
	} result_t;

endpackage

### rtl/amqpd_cfg.sv
// Configuration register file of the deframer: maximum frame size and type masks.
// Depends on amqpd_pkg.
`timescale 1ns / 1ps

module amqpd_cfg
	import amqpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	output cfg_t                 cfg
);

	logic [31:0]       max_q;
	logic [3:0][63:0]  mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= 32'(MAX_FRAME_RST);
			mask_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_FRAME: max_q     <= cfg_data[31:0];
				REG_MASK_0:    mask_q[0] <= cfg_data;
				REG_MASK_1:    mask_q[1] <= cfg_data;
				REG_MASK_2:    mask_q[2] <= cfg_data;
				REG_MASK_3:    mask_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.frame_limit = max_q;
	assign cfg.type_mask   = mask_q;

endmodule

### rtl/amqpd_parse.sv
// Front part of the deframer: frame-layout state machine that classifies each byte.
// Depends on amqpd_pkg and amqp_frame_deframer_macros.svh.
`timescale 1ns / 1ps
`include "amqp_frame_deframer_macros.svh"

module amqpd_parse
	import amqpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  cfg_t       cfg,
	output result_t    rec
);

	localparam logic [2:0] PH_SIZE = 3'd0;
	localparam logic [2:0] PH_DOFF = 3'd1;
	localparam logic [2:0] PH_TYPE = 3'd2;
	localparam logic [2:0] PH_EXT  = 3'd3;
	localparam logic [2:0] PH_BODY = 3'd4;
	localparam logic [2:0] PH_ERR  = 3'd5;

	logic [2:0]  phase_q, phase_d;
	logic [1:0]  size_cnt_q, size_cnt_d;
	logic [31:0] frame_len_q, frame_len_d;
	logic [9:0]  ext_rem_q, ext_rem_d;
	logic [31:0] body_rem_q, body_rem_d;
	logic [31:0] body_size_q, body_size_d;
	logic [7:0]  type_q, type_d;
	logic        sub_q, sub_d;

	logic [31:0] len_shift;
	logic [32:0] doff_diff;
	logic [9:0]  doff_bytes;

	assign len_shift  = {frame_len_q[23:0], data_byte};
	assign doff_bytes = {data_byte, 2'b00};
	assign doff_diff  = {1'b0, frame_len_q} - {23'd0, doff_bytes};

	always_comb begin
		phase_d     = phase_q;
		size_cnt_d  = size_cnt_q;
		frame_len_d = frame_len_q;
		ext_rem_d   = ext_rem_q;
		body_rem_d  = body_rem_q;
		body_size_d = body_size_q;
		type_d      = type_q;
		sub_d       = sub_q;
		rec         = '0;

		case (phase_q)
			PH_SIZE: begin
				frame_len_d = len_shift;
				size_cnt_d  = size_cnt_q + 2'd1;
				if (size_cnt_q == 2'd3) begin
					if (len_shift < 32'(MIN_FRAME)) begin
						phase_d        = PH_ERR;
						rec.error_code = ERR_SIZE_LOW;
					end else if (len_shift > cfg.frame_limit) begin
						phase_d        = PH_ERR;
						rec.error_code = ERR_SIZE_HIGH;
					end else begin
						phase_d = PH_DOFF;
					end
				end
			end
			PH_DOFF: begin
				body_size_d = doff_diff[31:0];
				ext_rem_d   = doff_bytes - 10'(EXT_HDR_BYTES);
				if (data_byte < 8'(MIN_DOFF)) begin
					phase_d        = PH_ERR;
					rec.error_code = ERR_DOFF_LOW;
				end else if (doff_diff[32]) begin
					phase_d        = PH_ERR;
					rec.error_code = ERR_DOFF_HIGH;
				end else begin
					phase_d = PH_TYPE;
				end
			end
			PH_TYPE: begin
				type_d         = data_byte;
				sub_d          = cfg.type_mask[data_byte];
				body_rem_d     = body_size_q;
				phase_d        = PH_EXT;
				rec.type_id    = data_byte;
				rec.body_size  = body_size_q;
			end
			PH_EXT: begin
				rec.type_id    = type_q;
				rec.body_size  = body_size_q;
				if (sub_q) begin
					rec.kind     = KIND_EXT;
					rec.out_byte = data_byte;
				end
				ext_rem_d = ext_rem_q - 10'd1;
				if (ext_rem_q == 10'd1) begin
					rec.header_done = sub_q;
					phase_d = (body_size_q == 32'd0) ? PH_SIZE : PH_BODY;
				end
			end
			PH_BODY: begin
				rec.type_id    = type_q;
				rec.body_size  = body_size_q;
				if (sub_q) begin
					rec.kind     = KIND_BODY;
					rec.out_byte = data_byte;
				end
				body_rem_d = body_rem_q - 32'd1;
				if (body_rem_q == 32'd1) begin
					rec.body_last = sub_q;
					phase_d       = PH_SIZE;
				end
			end
			default: begin
				phase_d        = PH_ERR;
				rec.error_code = ERR_STUCK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIZE;
			size_cnt_q  <= '0;
			frame_len_q <= '0;
			ext_rem_q   <= '0;
			body_rem_q  <= '0;
			body_size_q <= '0;
			type_q      <= '0;
			sub_q       <= 1'b0;
		end else if (take) begin
			phase_q     <= phase_d;
			size_cnt_q  <= size_cnt_d;
			frame_len_q <= frame_len_d;
			ext_rem_q   <= ext_rem_d;
			body_rem_q  <= body_rem_d;
			body_size_q <= body_size_d;
			type_q      <= type_d;
			sub_q       <= sub_d;
		end
	end

	// A delivered byte never carries an error, and the flags only ride on their own kind.
	`AMQPD_ASSERT_IMPL(a_kind_no_err, rec.kind != KIND_NONE, rec.error_code == ERR_NONE)
	`AMQPD_ASSERT_IMPL(a_hdone_kind, rec.header_done, rec.kind == KIND_EXT)
	`AMQPD_ASSERT_IMPL(a_blast_kind, rec.body_last, rec.kind == KIND_BODY)
	// Once in the error phase the parser never leaves it.
	`AMQPD_ASSERT_NEXT(a_err_sticky, phase_q == PH_ERR, phase_q == PH_ERR)

endmodule

### rtl/amqpd_fifo.sv
// Short result queue between the parser and the output stage.
// Depends on amqpd_pkg.
`timescale 1ns / 1ps

module amqpd_fifo
	import amqpd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  result_t wr_data,
	output logic    full,
	input  logic    rd_en,
	output logic    rd_valid,
	output result_t rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	result_t         mem [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr, do_rd;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;
	assign rd_data  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### rtl/amqpd_out.sv
// Back part of the deframer: output register that presents the oldest result.
// Depends on amqpd_pkg.
`timescale 1ns / 1ps

module amqpd_out
	import amqpd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	input  result_t q_data,
	output logic    q_take,
	output logic    empty,
	input  logic    pop,
	output result_t res
);

	logic    valid_q;
	result_t res_q;

	assign q_take = q_valid && (!valid_q || pop);
	assign empty  = !valid_q;
	assign res    = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			res_q <= q_data;
		end
	end

endmodule

### rtl/amqp_frame_deframer.sv
// Top level of the AMQP frame deframer: config registers, parser, result queue, output stage.
// Depends on amqpd_pkg, amqpd_cfg, amqpd_parse, amqpd_fifo and amqpd_out.
`timescale 1ns / 1ps

// The deframer takes one received byte per transfer on the push side and returns exactly one
// result per byte on the pop side, in order. It walks the frame layout: four big-endian size
// bytes (checked against 8 and the configured maximum frame length), the data-offset byte (at
// least 2 words and not beyond the frame), the type byte, the extended-header bytes and the
// body bytes. Bytes of a type whose mask bit is set come out with kind 1 (extended header,
// header_done on the last one) or kind 2 (body, body_last on the final one); other frames are
// counted and dropped with kind 0. A malformed header reports its error code once, and every
// later byte reports the stuck code until reset. The parser handles one byte per clock, so the
// block sustains one transfer per cycle on both sides while full stays low and pop stays high;
// a byte's result is written into the queue when it is transferred and then moves into the
// output register, where it stays on the result ports until it is popped. Results wait in a
// DEPTH-entry queue in front of the output register, and full rises only when that queue fills
// because pop stays low. There is no clearing pass after reset. Configuration registers are
// written through the cfg channel, which is always ready, and should only change while no byte
// is in flight.
module amqp_frame_deframer
	import amqpd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           data_byte,
	output logic                 empty,
	input  logic                 pop,
	output logic [1:0]           kind,
	output logic [7:0]           out_byte,
	output logic [7:0]           type_id,
	output logic [31:0]          body_size,
	output logic                 header_done,
	output logic                 body_last,
	output logic [2:0]           error_code,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	cfg_t    cfg;
	result_t rec;
	result_t q_data;
	result_t res;
	logic    take;
	logic    q_valid;
	logic    q_take;

	// A byte transfer happens whenever push is high and the queue has room for its result.
	assign take = push && !full;

	amqpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	amqpd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.cfg       (cfg),
		.rec       (rec)
	);

	amqpd_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (take),
		.wr_data  (rec),
		.full     (full),
		.rd_en    (q_take),
		.rd_valid (q_valid),
		.rd_data  (q_data)
	);

	amqpd_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_take  (q_take),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	assign kind        = res.kind;
	assign out_byte    = res.out_byte;
	assign type_id     = res.type_id;
	assign body_size   = res.body_size;
	assign header_done = res.header_done;
	assign body_last   = res.body_last;
	assign error_code  = res.error_code;

endmodule

### tb/amqp_frame_deframer_checker.sv
// Checker for the AMQP frame deframer: watches the byte, result and cfg channels.
// Keeps its own model of the frame parser and compares every popped result with it.
// Depends on amqpd_pkg for the result layout, kind, error and register codes.
`timescale 1ns / 1ps

module amqp_frame_deframer_checker
	import amqpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  logic [7:0]           data_byte,
	input  logic                 empty,
	input  logic                 pop,
	input  logic [1:0]           kind,
	input  logic [7:0]           out_byte,
	input  logic [7:0]           type_id,
	input  logic [31:0]          body_size,
	input  logic                 header_done,
	input  logic                 body_last,
	input  logic [2:0]           error_code,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	output int                   mismatches,
	output int                   outstanding
);

	typedef enum logic [2:0] {
		SEEK_SIZE,
		SEEK_DOFF,
		SEEK_TYPE,
		IN_EXT_HDR,
		IN_BODY,
		STUCK
	} parse_phase_e;

	logic [31:0]  max_frame;
	logic [255:0] sub_mask;
	parse_phase_e phase;
	logic [31:0]  position;
	logic [31:0]  frame_len;
	logic [7:0]   doff_words;
	logic [7:0]   cur_type;
	logic         subscribed;

	result_t      awaited_results[$];
	result_t      oldest;

	function automatic void start_next_frame();
		phase     = SEEK_SIZE;
		position  = '0;
		frame_len = '0;
	endfunction

	// Advances the parser model by one byte and returns what the block should report for it.
	function automatic result_t decode_byte(input logic [7:0] b);
		result_t     r;
		logic [31:0] hdr_len;
		logic [31:0] body_len;
		r = '0;
		hdr_len  = {22'd0, doff_words, 2'b00};
		body_len = frame_len - hdr_len;
		case (phase)
			SEEK_SIZE: begin
				frame_len = {frame_len[23:0], b};
				position  = position + 1;
				if (position >= 4) begin
					position = '0;
					if (frame_len < MIN_FRAME) begin
						phase        = STUCK;
						r.error_code = ERR_SIZE_LOW;
					end else if (frame_len > max_frame) begin
						phase        = STUCK;
						r.error_code = ERR_SIZE_HIGH;
					end else begin
						phase = SEEK_DOFF;
					end
				end
			end
			SEEK_DOFF: begin
				doff_words = b;
				if (b < MIN_DOFF) begin
					phase        = STUCK;
					r.error_code = ERR_DOFF_LOW;
				end else if ({22'd0, b, 2'b00} > frame_len) begin
					phase        = STUCK;
					r.error_code = ERR_DOFF_HIGH;
				end else begin
					phase = SEEK_TYPE;
				end
			end
			SEEK_TYPE: begin
				cur_type     = b;
				subscribed   = sub_mask[b];
				position     = '0;
				phase        = IN_EXT_HDR;
				r.type_id    = b;
				r.body_size  = body_len;
			end
			IN_EXT_HDR: begin
				r.type_id    = cur_type;
				r.body_size  = body_len;
				if (subscribed) begin
					r.kind     = KIND_EXT;
					r.out_byte = b;
				end
				position = position + 1;
				if (position >= hdr_len - EXT_HDR_BYTES) begin
					r.header_done = subscribed;
					if (body_len == 0) begin
						start_next_frame();
					end else begin
						phase    = IN_BODY;
						position = '0;
					end
				end
			end
			IN_BODY: begin
				r.type_id    = cur_type;
				r.body_size  = body_len;
				if (subscribed) begin
					r.kind     = KIND_BODY;
					r.out_byte = b;
				end
				position = position + 1;
				if (position >= body_len) begin
					r.body_last = subscribed;
					start_next_frame();
				end
			end
			default: begin
				phase        = STUCK;
				r.error_code = ERR_STUCK;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch(what, got, want);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame   = MAX_FRAME_RST;
			sub_mask    = '0;
			phase       = SEEK_SIZE;
			position    = '0;
			frame_len   = '0;
			doff_words  = '0;
			cur_type    = '0;
			subscribed  = 1'b0;
			mismatches  = 0;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_FRAME: max_frame = cfg_data[31:0];
					REG_MASK_0:    sub_mask[63:0] = cfg_data;
					REG_MASK_1:    sub_mask[127:64] = cfg_data;
					REG_MASK_2:    sub_mask[191:128] = cfg_data;
					REG_MASK_3:    sub_mask[255:192] = cfg_data;
					default:       ;
				endcase
			end
			if (push && !full) begin
				awaited_results.push_back(decode_byte(data_byte));
			end
			if (pop && !empty) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result, kind", 32'(kind), 32'(KIND_NONE));
				end else begin
					oldest = awaited_results.pop_front();
					check_field("kind", 32'(kind), 32'(oldest.kind));
					check_field("out_byte", 32'(out_byte), 32'(oldest.out_byte));
					check_field("type_id", 32'(type_id), 32'(oldest.type_id));
					check_field("body_size", body_size, oldest.body_size);
					check_field("header_done", 32'(header_done), 32'(oldest.header_done));
					check_field("body_last", 32'(body_last), 32'(oldest.body_last));
					check_field("error_code", 32'(error_code), 32'(oldest.error_code));
				end
			end
			outstanding <= awaited_results.size();
		end
	end

endmodule

### tb/amqp_frame_deframer_test.sv
// Top of the AMQP frame deframer testbench: clock, reset, byte stream, pop side and verdict.
// Depends on amqpd_pkg, the amqp_frame_deframer RTL and amqp_frame_deframer_checker.
`timescale 1ns / 1ps

module amqp_frame_deframer_test;
	import amqpd_pkg::*;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic [7:0]           data_byte = '0;
	logic                 pop = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data = '0;

	logic                 full;
	logic                 empty;
	logic [1:0]           kind;
	logic [7:0]           out_byte;
	logic [7:0]           type_id;
	logic [31:0]          body_size;
	logic                 header_done;
	logic                 body_last;
	logic [2:0]           error_code;
	logic                 cfg_ready;

	int                   mismatches;
	int                   outstanding;

	// While steady is set neither side inserts gaps, so the block runs at full rate.
	bit                   steady = 1'b0;
	int                   bytes_sent = 0;
	// Mirror of the programmed maximum frame length, used to keep random frames legal.
	logic [31:0]          max_setting = MAX_FRAME_RST;

	amqp_frame_deframer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.out_byte    (out_byte),
		.type_id     (type_id),
		.body_size   (body_size),
		.header_done (header_done),
		.body_last   (body_last),
		.error_code  (error_code),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	amqp_frame_deframer_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.out_byte    (out_byte),
		.type_id     (type_id),
		.body_size   (body_size),
		.header_done (header_done),
		.body_last   (body_last),
		.error_code  (error_code),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// A generous fixed bound; a correct run with the longest stalls needs a small part of it.
	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

	// Gap lengths: mostly none, often a few cycles, now and then a long pause that lets the
	// result queue fill up and push full back at the sender.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// One byte transfer. Push stays high when no gap follows, so back-to-back bytes never
	// lower and raise push in the same step.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		push      <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (full);
		bytes_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// The size field goes out most significant byte first.
	task automatic send_size(input logic [31:0] size);
		send_byte(size[31:24]);
		send_byte(size[23:16]);
		send_byte(size[15:8]);
		send_byte(size[7:0]);
	endtask

	// A well-formed frame. A negative fill gives random header and body bytes.
	task automatic send_frame(input int doff, input int body, input logic [7:0] ftype,
			input int fill);
		send_size(32'(doff * 4 + body));
		send_byte(8'(doff));
		send_byte(ftype);
		repeat (doff * 4 - EXT_HDR_BYTES)
			send_byte(8'(fill < 0 ? $urandom_range(0, 255) : fill));
		repeat (body) send_byte(8'(fill < 0 ? $urandom_range(0, 255) : fill));
	endtask

	// Random legal frame. Most have a short header and a short body; a few use long extended
	// headers, empty bodies or fill the frame exactly up to the maximum length or 300 bytes, whichever is less.
	task automatic random_frame();
		int lim;
		int doff_hi;
		int doff;
		int body_hi;
		int body;
		int r;
		lim     = (max_setting > 300) ? 300 : int'(max_setting);
		doff_hi = (lim / 4 > 64) ? 64 : lim / 4;
		r       = $urandom_range(0, 99);
		doff    = (r < 85) ? $urandom_range(2, (doff_hi < 4) ? doff_hi : 4)
			: $urandom_range(2, doff_hi);
		body_hi = lim - doff * 4;
		r       = $urandom_range(0, 99);
		if (r < 15) begin
			body = 0;
		end else if (r < 90) begin
			body = $urandom_range(0, (body_hi < 12) ? body_hi : 12);
		end else if (r < 97) begin
			body = $urandom_range(0, (body_hi < 60) ? body_hi : 60);
		end else begin
			body = body_hi;
		end
		send_frame(doff, body, 8'($urandom_range(0, 255)), -1);
	endtask

	// Stops the byte stream and waits until every transfer has its result back, so the
	// registers can be changed with nothing in flight.
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// One register write; valid drops for a cycle so two writes never touch it in one step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Writes all five registers for one phase of the random run. The upper word of the
	// maximum frame length write carries junk that the block must ignore.
	task automatic apply_setting(input int sel);
		logic [31:0] mx;
		logic [63:0] masks [4];
		for (int k = 0; k < 4; k++) begin
			masks[k] = {$urandom, $urandom};
		end
		case (sel)
			0: mx = 32'hFFFF_FFFF;
			1: begin
				mx = MIN_FRAME;
				for (int k = 0; k < 4; k++) begin
					masks[k] = '1;
				end
			end
			2: mx = $urandom_range(8, 120);
			3: begin
				mx = MAX_FRAME_RST;
				for (int k = 0; k < 4; k++) begin
					masks[k] = '0;
				end
			end
			4: mx = $urandom_range(100, 2000);
			default: mx = $urandom_range(8, 1000);
		endcase
		write_reg(REG_MAX_FRAME, {$urandom, mx});
		max_setting = mx;
		write_reg(REG_MASK_0, masks[0]);
		write_reg(REG_MASK_1, masks[1]);
		write_reg(REG_MASK_2, masks[2]);
		write_reg(REG_MASK_3, masks[3]);
	endtask

	// The pop side runs on its own: bursts of pop high separated by random stalls.
	initial begin
		int gap;
		int burst;
		do @(posedge clk); while (!arst_n);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			burst = steady ? 30 : $urandom_range(1, 12);
			repeat (burst) @(posedge clk);
		end
	end

	initial begin
		int          ph;
		int          stop;
		int          target;
		int          sel;
		int          s;
		logic [31:0] mx;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames: type 0 and type 255 subscribed, all-ones and all-zeros content,
		// a minimal frame with an empty body, one with a body, and an unsubscribed one.
		write_reg(REG_MASK_0, 64'h1);
		write_reg(REG_MASK_3, 64'h8000_0000_0000_0000);
		send_frame(MIN_DOFF, 0, 8'h00, 8'hFF);
		send_frame(MIN_DOFF, 4, 8'hFF, 8'h00);
		send_frame(MIN_DOFF, 0, 8'h80, -1);

		// Random frames in phases; the block is drained and reprogrammed between phases.
		target = bytes_sent + 450;
		ph     = 0;
		while (bytes_sent < target) begin
			drain();
			apply_setting(ph % 6);
			steady = (ph % 6 == 4);
			stop   = bytes_sent + 70;
			while (bytes_sent < stop && bytes_sent < target) begin
				random_frame();
			end
			ph++;
		end
		drain();
		steady = 1'b0;

		// Errors are sticky until reset, and reset happens only once, so the run ends with
		// one malformed header chosen at random, followed by bytes that must all report the
		// stuck code.
		sel = $urandom_range(0, 4);
		case (sel)
			0: begin
				// A maximum below the minimum frame size rejects any size.
				mx = $urandom_range(0, MIN_FRAME - 1);
				write_reg(REG_MAX_FRAME, {32'd0, mx});
				send_size($urandom_range(0, 100));
			end
			1: send_size($urandom_range(0, MIN_FRAME - 1));
			2: begin
				mx = $urandom_range(8, 1000);
				write_reg(REG_MAX_FRAME, {$urandom, mx});
				send_size($urandom_range(0, 1) ? mx + 1 : (32'h8000_0000 | $urandom));
			end
			3: begin
				send_size($urandom_range(12, 40));
				send_byte(8'($urandom_range(0, MIN_DOFF - 1)));
			end
			default: begin
				s = $urandom_range(8, 40);
				send_size(s);
				send_byte(8'($urandom_range(s / 4 + 1, 255)));
			end
		endcase
		repeat ($urandom_range(8, 24)) send_byte(8'($urandom_range(0, 255)));
		drain();

		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
